// ----- hw/rtl/lsep_pkg.sv -----
// ----------------------------------------------------------------------------
// lsep_pkg
// Shared types, class codes, register map and the correction table builder
// for the pairwise log-sum-exp block.
// ----------------------------------------------------------------------------
package lsep_pkg;

  localparam int VALUE_WIDTH      = 24;
  localparam int CUTOFF_WIDTH     = 23;
  localparam int STEP_SHIFT       = 4;
  localparam int FRAC_BITS_DEF    = 12;
  localparam int CORR_ENTRIES_DEF = 256;

  localparam logic [CUTOFF_WIDTH-1:0] CUTOFF_RESET = CUTOFF_WIDTH'(409600);

  localparam int CMP_W = ((VALUE_WIDTH + 1 > CUTOFF_WIDTH + 1) ?
                          VALUE_WIDTH + 1 : CUTOFF_WIDTH + 1) + 1;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_CUTOFF = 1'b0;

  localparam logic [1:0] CLASS_FINITE  = 2'd0;
  localparam logic [1:0] CLASS_POS_INF = 2'd1;
  localparam logic [1:0] CLASS_NEG_INF = 2'd2;

  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] x_value;
    logic [1:0]                    x_class;
    logic signed [VALUE_WIDTH-1:0] y_value;
    logic [1:0]                    y_class;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sum_value;
    logic [1:0]                    sum_class;
    logic                          saturated;
  } out_item_t;

  // Shift-and-subtract division, used only while the table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k holds ln(1 + exp(-k/16)) rounded to frac_bits fraction bits, built
  // with truncating Q32 arithmetic.
  function automatic logic [63:0] corr_entry(input int k, input int frac_bits);
    logic [63:0] c;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] s;
    logic [63:0] pw;
    logic [63:0] ln;
    int n;
    int m;
    c    = 64'd1 << 32;
    term = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (n = 1; term != 64'd0 && n < 64; n++) begin
      term = udiv64(term >> STEP_SHIFT, 64'(n));
      if (n % 2 == 1) begin
        c = c - term;
      end else begin
        c = c + term;
      end
    end
    for (int j = 0; j < k; j++) begin
      e = (e * c) >> 32;
    end
    z  = udiv64(e << 31, e + (64'd1 << 33)) << 1;
    z2 = (z * z) >> 32;
    s  = '0;
    pw = z;
    for (m = 1; pw != 64'd0 && m < 200; m += 2) begin
      s  = s + udiv64(pw, 64'(m));
      pw = (pw * z2) >> 32;
    end
    ln = s << 1;
    return (ln + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits);
  endfunction

endpackage

// ----- hw/rtl/lsep_corr_rom.sv -----
// ----------------------------------------------------------------------------
// lsep_corr_rom
// Constant correction table ln(1 + exp(-k/16)), read combinationally.
// ----------------------------------------------------------------------------
module lsep_corr_rom #(
  parameter int FRAC_BITS          = lsep_pkg::FRAC_BITS_DEF,
  parameter int CORRECTION_ENTRIES = lsep_pkg::CORR_ENTRIES_DEF,
  localparam int IDX_W = $clog2(CORRECTION_ENTRIES)
) (
  input  logic [IDX_W-1:0]     idx,
  output logic [FRAC_BITS-1:0] corr
);

  logic [FRAC_BITS-1:0] rom_tab [CORRECTION_ENTRIES];

  for (genvar k = 0; k < CORRECTION_ENTRIES; k++) begin : g_tab
    localparam logic [63:0] ENTRY = lsep_pkg::corr_entry(k, FRAC_BITS);
    assign rom_tab[k] = ENTRY[FRAC_BITS-1:0];
  end

  always_comb begin
    if (32'(idx) < 32'(CORRECTION_ENTRIES)) begin
      corr = rom_tab[idx];
    end else begin
      corr = '0;
    end
  end

endmodule

// ----- hw/rtl/lsep_core.sv -----
// ----------------------------------------------------------------------------
// lsep_core
// Single-pass max-star datapath: class handling, cutoff compare, table
// correction and saturation.
// ----------------------------------------------------------------------------
module lsep_core #(
  parameter int FRAC_BITS          = lsep_pkg::FRAC_BITS_DEF,
  parameter int CORRECTION_ENTRIES = lsep_pkg::CORR_ENTRIES_DEF
) (
  input  lsep_pkg::in_item_t                    item,
  input  logic [lsep_pkg::CUTOFF_WIDTH-1:0]     cutoff,
  output lsep_pkg::out_item_t                   result
);

  localparam int VW    = lsep_pkg::VALUE_WIDTH;
  localparam int CW    = lsep_pkg::CMP_W;
  localparam int IDX_W = $clog2(CORRECTION_ENTRIES);

  logic                  x_inf;
  logic                  y_inf;
  logic signed [CW-1:0]  d_w;
  logic signed [CW-1:0]  neg_d;
  logic signed [CW-1:0]  cut_w;
  logic signed [CW-1:0]  ncut_w;
  logic [VW:0]           ad;
  logic [VW:0]           idx_full;
  logic                  idx_ok;
  logic [FRAC_BITS-1:0]  rom_corr;
  logic [FRAC_BITS-1:0]  corr;
  logic signed [VW-1:0]  mx;
  logic signed [VW:0]    sum_w;
  logic                  ovf;

  assign x_inf = (item.x_class == lsep_pkg::CLASS_POS_INF) ||
                 (item.x_class == lsep_pkg::CLASS_NEG_INF);
  assign y_inf = (item.y_class == lsep_pkg::CLASS_POS_INF) ||
                 (item.y_class == lsep_pkg::CLASS_NEG_INF);

  assign d_w    = CW'(item.x_value) - CW'(item.y_value);
  assign neg_d  = -d_w;
  assign cut_w  = {{(CW-lsep_pkg::CUTOFF_WIDTH){1'b0}}, cutoff};
  assign ncut_w = -cut_w;

  assign ad       = d_w[CW-1] ? neg_d[VW:0] : d_w[VW:0];
  assign idx_full = ad >> (FRAC_BITS - lsep_pkg::STEP_SHIFT);
  assign idx_ok   = idx_full < (VW+1)'(CORRECTION_ENTRIES);

  lsep_corr_rom #(
    .FRAC_BITS          (FRAC_BITS),
    .CORRECTION_ENTRIES (CORRECTION_ENTRIES)
  ) u_rom (
    .idx  (idx_full[IDX_W-1:0]),
    .corr (rom_corr)
  );

  assign corr  = idx_ok ? rom_corr : '0;
  assign mx    = (item.x_value > item.y_value) ? item.x_value : item.y_value;
  assign sum_w = {mx[VW-1], mx} + $signed({{(VW+1-FRAC_BITS){1'b0}}, corr});
  assign ovf   = !sum_w[VW] && sum_w[VW-1];

  always_comb begin
    result.sum_value = '0;
    result.sum_class = lsep_pkg::CLASS_FINITE;
    result.saturated = 1'b0;
    if (x_inf && !y_inf) begin
      result.sum_value = item.y_value;
    end else if (!x_inf && y_inf) begin
      result.sum_value = item.x_value;
    end else if (x_inf && y_inf) begin
      result.sum_class = item.x_class;
    end else if (d_w >= cut_w) begin
      result.sum_value = item.x_value;
    end else if (d_w <= ncut_w) begin
      result.sum_value = item.y_value;
    end else if (ovf) begin
      result.sum_value = lsep_pkg::VALUE_MAX;
      result.saturated = 1'b1;
    end else begin
      result.sum_value = sum_w[VW-1:0];
    end
  end

endmodule

// ----- hw/rtl/lsep_cfg.sv -----
// ----------------------------------------------------------------------------
// lsep_cfg
// APB-style register slave holding the difference cutoff.
// ----------------------------------------------------------------------------
module lsep_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lsep_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lsep_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lsep_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [lsep_pkg::CUTOFF_WIDTH-1:0] cutoff
);

  logic [lsep_pkg::CUTOFF_WIDTH-1:0] cutoff_r;
  logic [lsep_pkg::CUTOFF_WIDTH-1:0] cutoff_nxt;
  logic                              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[lsep_pkg::APB_ADDR_W-1] == lsep_pkg::REG_CUTOFF;

  always_comb begin
    cutoff_nxt = cutoff_r;
    if (psel && penable && pwrite && reg_hit) begin
      cutoff_nxt = pwdata[lsep_pkg::CUTOFF_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= lsep_pkg::CUTOFF_RESET;
    end else begin
      cutoff_r <= cutoff_nxt;
    end
  end

  assign prdata = reg_hit ?
                  {{(lsep_pkg::APB_DATA_W-lsep_pkg::CUTOFF_WIDTH){1'b0}}, cutoff_r} : '0;
  assign cutoff = cutoff_r;

endmodule

// ----- hw/rtl/log_sum_exp_pair_top.sv -----
// ----------------------------------------------------------------------------
// log_sum_exp_pair_top
// Pairwise Jacobian logarithm ln(exp(x) + exp(y)) on Q fixed point operands.
// Path: an accepted input is held in the input register, and its result is
// then registered in the result register, which drives out_valid/out_data.
// Throughput: one item per cycle unless out_stall holds the result register;
// the two-stage pipeline advances whenever the next stage is free.
// Reset: synchronous; both stages empty, the cutoff returns to 100.0.
// ----------------------------------------------------------------------------
module log_sum_exp_pair_top #(
  parameter int FRAC_BITS          = lsep_pkg::FRAC_BITS_DEF,
  parameter int CORRECTION_ENTRIES = lsep_pkg::CORR_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lsep_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lsep_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsep_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lsep_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lsep_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  lsep_pkg::in_item_t                s1_item_r;
  logic                              s2_valid_r;
  logic                              s2_valid_nxt;
  lsep_pkg::out_item_t               s2_item_r;
  lsep_pkg::out_item_t               core_res;
  logic [lsep_pkg::CUTOFF_WIDTH-1:0] cutoff;
  logic                              s2_load;
  logic                              s1_load;

  lsep_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cutoff  (cutoff)
  );

  lsep_core #(
    .FRAC_BITS          (FRAC_BITS),
    .CORRECTION_ENTRIES (CORRECTION_ENTRIES)
  ) u_core (
    .item   (s1_item_r),
    .cutoff (cutoff),
    .result (core_res)
  );

  assign s2_load  = !s2_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  always_comb begin
    s1_valid_nxt = s1_load ? in_valid : s1_valid_r;
    s2_valid_nxt = s2_load ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s2_load && s1_valid_r) begin
      s2_item_r <= core_res;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_item_r;

  // A clipped result is always finite and pinned to the largest value.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.sum_class == lsep_pkg::CLASS_FINITE &&
      out_data.sum_value == lsep_pkg::VALUE_MAX)
    else $error("saturated result is not the finite maximum");

  // Two infinite operands give a zero value field and no clip flag.
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sum_class != lsep_pkg::CLASS_FINITE |->
      out_data.sum_value == '0 && !out_data.saturated)
    else $error("infinite result carries a value");

  // The input side only stalls while both registers hold items and out_stall is high.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s2_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // A stalled result stays in the result register unchanged.
  a_hold_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && out_stall |=> s2_valid_r && $stable(s2_item_r))
    else $error("result register changed while stalled");

endmodule

// ----- sim/tb_log_sum_exp_pair_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_sum_exp_pair_top
// Self-checking bench for the pairwise log-sum-exp block. Operand pairs are
// sent in bursts while the result side stalls on its own random pattern. Each
// accepted pair is run through a local predictor with its own copy of the
// correction table and the cutoff register. Results are compared field by
// field in order. The cutoff is rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_log_sum_exp_pair_top;
  import lsep_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int ENTRIES   = CORR_ENTRIES_DEF;
  localparam int LATENCY   = 2;
  localparam logic [1:0] CLASS_SPARE = 2'd3;
  localparam logic [APB_ADDR_W-1:0] CUTOFF_ADDR = APB_ADDR_W'(4 * REG_CUTOFF);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [63:0]             ln_corr_rom [ENTRIES];
  logic [CUTOFF_WIDTH-1:0] cutoff_q12 = CUTOFF_RESET;
  out_item_t               expected_sums [$];
  out_item_t               oldest_sum;
  int                      errors       = 0;
  int                      stall_pct    = 0;
  int                      hold_request = 0;
  int                      hold_count   = 0;

  log_sum_exp_pair_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  initial begin : build_corr_table
    logic [63:0] c;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] s;
    logic [63:0] pw;
    logic [63:0] ln;
    int n;
    int m;
    c    = 64'd1 << 32;
    term = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (n = 1; term != 64'd0 && n < 64; n++) begin
      term = (term >> STEP_SHIFT) / 64'(n);
      if (n % 2 == 1) begin
        c = c - term;
      end else begin
        c = c + term;
      end
    end
    for (int k = 0; k < ENTRIES; k++) begin
      z  = ((e << 31) / (e + (64'd1 << 33))) << 1;
      z2 = (z * z) >> 32;
      s  = '0;
      pw = z;
      for (m = 1; pw != 64'd0 && m < 200; m += 2) begin
        s  = s + pw / 64'(m);
        pw = (pw * z2) >> 32;
      end
      ln = s << 1;
      ln_corr_rom[k] = (ln + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
      e = (e * c) >> 32;
    end
  end

  function automatic out_item_t predict_log_sum(input in_item_t it);
    out_item_t   r;
    logic        x_inf;
    logic        y_inf;
    longint      x;
    longint      y;
    longint      d;
    longint      cut;
    longint      mx;
    longint      sum;
    longint      corr;
    longint      idx;
    r     = '0;
    x     = longint'($signed(it.x_value));
    y     = longint'($signed(it.y_value));
    cut   = longint'(cutoff_q12);
    x_inf = (it.x_class == CLASS_POS_INF) || (it.x_class == CLASS_NEG_INF);
    y_inf = (it.y_class == CLASS_POS_INF) || (it.y_class == CLASS_NEG_INF);
    d     = x - y;
    r.sum_class = CLASS_FINITE;
    if (x_inf && !y_inf) begin
      r.sum_value = it.y_value;
    end else if (!x_inf && y_inf) begin
      r.sum_value = it.x_value;
    end else if (x_inf && y_inf) begin
      r.sum_class = it.x_class;
    end else if (d >= cut) begin
      r.sum_value = it.x_value;
    end else if (d <= -cut) begin
      r.sum_value = it.y_value;
    end else begin
      idx  = ((d < 0) ? -d : d) >> (FRAC - STEP_SHIFT);
      corr = (idx < ENTRIES) ? longint'(ln_corr_rom[idx]) : 0;
      mx   = (x > y) ? x : y;
      sum  = mx + corr;
      if (sum > longint'($signed(VALUE_MAX))) begin
        sum         = longint'($signed(VALUE_MAX));
        r.saturated = 1'b1;
      end
      r.sum_value = VALUE_WIDTH'(sum);
    end
    return r;
  endfunction

  function automatic in_item_t make_pair(input longint xv, input logic [1:0] xc,
                                         input longint yv, input logic [1:0] yc);
    in_item_t it;
    it.x_value = VALUE_WIDTH'(xv);
    it.x_class = xc;
    it.y_value = VALUE_WIDTH'(yv);
    it.y_class = yc;
    return it;
  endfunction

  function automatic logic [1:0] random_class();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return CLASS_POS_INF;
    end else if (r == 1) begin
      return CLASS_NEG_INF;
    end else if (r == 2) begin
      return CLASS_SPARE;
    end
    return CLASS_FINITE;
  endfunction

  // Four in ten pairs sit close together so that the correction table is used; some
  // straddle the current cutoff, some push the sum past the largest value, and the rest are random.
  function automatic in_item_t random_pair();
    longint x;
    longint y;
    longint d;
    int     pick;
    x    = longint'($signed(VALUE_WIDTH'($urandom)));
    y    = longint'($signed(VALUE_WIDTH'($urandom)));
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      y = x + longint'($urandom_range(0, 140000)) - 70000;
    end else if (pick == 4) begin
      x = longint'($signed(VALUE_MAX)) - longint'($urandom_range(0, 8000));
      y = x - longint'($urandom_range(0, 4000));
    end else if (pick == 5) begin
      d = longint'(cutoff_q12) + longint'($urandom_range(0, 4)) - 2;
      y = ($urandom_range(0, 1) == 1) ? x - d : x + d;
    end
    if ($urandom_range(0, 1) == 1) begin
      return make_pair(y, random_class(), x, random_class());
    end
    return make_pair(x, random_class(), y, random_class());
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'(out_data));
      end else begin
        oldest_sum = expected_sums.pop_front();
        if (out_data.sum_value !== oldest_sum.sum_value) begin
          report_mismatch("sum_value", 64'(oldest_sum.sum_value), 64'(out_data.sum_value));
        end
        if (out_data.sum_class !== oldest_sum.sum_class) begin
          report_mismatch("sum_class", 64'(oldest_sum.sum_class), 64'(out_data.sum_class));
        end
        if (out_data.saturated !== oldest_sum.saturated) begin
          report_mismatch("saturated", 64'(oldest_sum.saturated), 64'(out_data.saturated));
        end
      end
    end
  end

  // The result side stalls at random, or for a long requested stretch.
  always @(negedge clk) begin
    if (hold_count == 0 && hold_request != 0) begin
      hold_count   = hold_request;
      hold_request = 0;
    end
    if (hold_count != 0) begin
      hold_count--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic put_item(input in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_sums.push_back(predict_log_sum(it));
  endtask

  task automatic pause_input(input int cycles);
    repeat (cycles) @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    pause_input(1);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_random_items(input int count, input int gap_max);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        put_item(random_pair());
        sent++;
      end
      if (gap_max > 0) begin
        pause_input($urandom_range(0, gap_max));
      end
    end
  endtask

  task automatic apb_transfer(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_cutoff_readback();
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b0, CUTOFF_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(cutoff_q12)) begin
      report_mismatch("cutoff readback", 64'(cutoff_q12), 64'(rd));
    end
  endtask

  task automatic set_cutoff(input logic [CUTOFF_WIDTH-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    wait_all_results();
    apb_transfer(1'b1, CUTOFF_ADDR, APB_DATA_W'(value), rd);
    cutoff_q12 = value;
    check_cutoff_readback();
  endtask

  task automatic test_directed();
    longint vmax;
    longint vmin;
    vmax      = longint'($signed(VALUE_MAX));
    vmin      = -vmax - 1;
    stall_pct = 30;
    check_cutoff_readback();
    put_item(make_pair(vmax, CLASS_FINITE, vmax, CLASS_FINITE));
    put_item(make_pair(vmin, CLASS_FINITE, vmin, CLASS_FINITE));
    put_item(make_pair(0, CLASS_FINITE, 0, CLASS_FINITE));
    put_item(make_pair(vmax, CLASS_FINITE, vmin, CLASS_FINITE));
    put_item(make_pair(vmin, CLASS_FINITE, vmax, CLASS_FINITE));
    put_item(make_pair(409600, CLASS_FINITE, 0, CLASS_FINITE));
    put_item(make_pair(0, CLASS_FINITE, 409600, CLASS_FINITE));
    put_item(make_pair(409599, CLASS_FINITE, 0, CLASS_FINITE));
    put_item(make_pair(65535, CLASS_FINITE, 0, CLASS_FINITE));
    put_item(make_pair(0, CLASS_FINITE, 65536, CLASS_FINITE));
    put_item(make_pair(-4096, CLASS_FINITE, 4096, CLASS_FINITE));
    put_item(make_pair(vmax - 100, CLASS_FINITE, vmax - 50, CLASS_FINITE));
    put_item(make_pair(vmax - 3000, CLASS_FINITE, vmax - 200000, CLASS_FINITE));
    put_item(make_pair(777, CLASS_POS_INF, 1234, CLASS_FINITE));
    put_item(make_pair(-5, CLASS_NEG_INF, vmin, CLASS_FINITE));
    put_item(make_pair(vmax, CLASS_FINITE, 99, CLASS_POS_INF));
    put_item(make_pair(-8191, CLASS_FINITE, vmin, CLASS_NEG_INF));
    put_item(make_pair(vmax, CLASS_POS_INF, vmin, CLASS_POS_INF));
    put_item(make_pair(123, CLASS_POS_INF, 456, CLASS_NEG_INF));
    put_item(make_pair(-1, CLASS_NEG_INF, 1, CLASS_POS_INF));
    put_item(make_pair(vmin, CLASS_NEG_INF, vmax, CLASS_NEG_INF));
    put_item(make_pair(2048, CLASS_SPARE, 1024, CLASS_FINITE));
    put_item(make_pair(-300, CLASS_SPARE, -200, CLASS_SPARE));
    put_item(make_pair(5000, CLASS_SPARE, 17, CLASS_POS_INF));
    put_item(make_pair(vmax, CLASS_NEG_INF, -4096, CLASS_SPARE));
  endtask

  task automatic test_cutoff_settings();
    logic [CUTOFF_WIDTH-1:0] cutoffs [6];
    longint cut;
    longint x;
    cutoffs = '{CUTOFF_WIDTH'(0), CUTOFF_WIDTH'(1), CUTOFF_WIDTH'(4096),
                CUTOFF_WIDTH'(65536), {CUTOFF_WIDTH{1'b1}}, CUTOFF_RESET};
    foreach (cutoffs[i]) begin
      stall_pct = 10 * i;
      set_cutoff(cutoffs[i]);
      cut = longint'(cutoffs[i]);
      x   = longint'($signed(VALUE_WIDTH'($urandom)));
      put_item(make_pair(x, CLASS_FINITE, x, CLASS_FINITE));
      put_item(make_pair(cut, CLASS_FINITE, 0, CLASS_FINITE));
      put_item(make_pair(0, CLASS_FINITE, cut, CLASS_FINITE));
      if (cut > 0) begin
        put_item(make_pair(cut - 1, CLASS_FINITE, 0, CLASS_FINITE));
        put_item(make_pair(0, CLASS_FINITE, cut - 1, CLASS_FINITE));
      end
      send_random_items(90, 4);
    end
  endtask

  task automatic test_random_traffic();
    int pct [7];
    pct = '{0, 20, 50, 80, 35, 10, 65};
    foreach (pct[i]) begin
      stall_pct = pct[i];
      send_random_items(100, (i % 3) * 4);
    end
  endtask

  task automatic test_full_rate();
    stall_pct = 0;
    send_random_items(200, 0);
  endtask

  task automatic test_output_hold();
    stall_pct = 20;
    put_item(random_pair());
    hold_request = 300;
    send_random_items(100, 0);
  endtask

  task automatic test_sender_pause();
    stall_pct = 40;
    send_random_items(50, 3);
    wait_all_results();
    send_random_items(50, 3);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    test_cutoff_settings();
    test_random_traffic();
    test_full_rate();
    test_output_hold();
    test_sender_pause();
    wait_all_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lsep_pkg.sv
hw/rtl/lsep_corr_rom.sv
hw/rtl/lsep_core.sv
hw/rtl/lsep_cfg.sv
hw/rtl/log_sum_exp_pair_top.sv
sim/tb_log_sum_exp_pair_top.sv
